>>> hdl/hsv2rgb_pkg.sv
// Shared constants for the HSV to RGB converter.
// No dependencies; imported by the converter and its port checker.
package hsv2rgb_pkg;

  // Default number of fraction bits; 1 << FRAC_BITS stands for 1.0
  localparam int FRAC_BITS_DEF = 16;

  // Stages from input register to output register
  localparam int PIPE_DEPTH = 5;

  // Sector index width: hue*6 stays below 12 for any legal hue
  localparam int SECT_W = 4;

  // Sector codes; sector 0 and every code above 5 take the red-to-yellow case
  localparam logic [SECT_W-1:0] SECT_YELLOW  = 4'd1;
  localparam logic [SECT_W-1:0] SECT_GREEN   = 4'd2;
  localparam logic [SECT_W-1:0] SECT_CYAN    = 4'd3;
  localparam logic [SECT_W-1:0] SECT_BLUE    = 4'd4;
  localparam logic [SECT_W-1:0] SECT_MAGENTA = 4'd5;

endpackage

>>> hdl/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter, five register stages, one word per cycle while m_axis is not stalled.
// Depends on hsv2rgb_pkg.
//
//   channel  | dir | tdata fields (low bit up)           | width
//   s_axis   | in  | hue, saturation, brightness         | 3*(FRAC_BITS+1), byte padded
//   m_axis   | out | red, green, blue                    | 3*(FRAC_BITS+1), byte padded
//
// One word enters per cycle unless m_axis stalls; each word passes every stage in order.
// The chain of stages is hue*6, s*f, 1-x, v*factor, sector select.
// Reset clears the stage valid bits only; payload registers are not reset.
// Each stage holds while the next one is full and stalled, so a stall on
// m_axis backs up stage by stage without loss or repeat; an empty stage
// still takes a word, so bubbles close up.
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF,
  parameter int DATA_W    = ((3 * (FRAC_BITS + 1) + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // hue, saturation, brightness, zero pad
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata   // red, green, blue, zero pad
);
  import hsv2rgb_pkg::*;

  localparam int VAL_W = FRAC_BITS + 1;
  localparam int H6_W  = VAL_W + 3;
  localparam int PAD_W = DATA_W - 3 * VAL_W;
  localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

  // 1 - x clamped at zero
  function automatic logic [VAL_W-1:0] sub_one(input logic [VAL_W-1:0] x);
    return (x >= ONE) ? '0 : (ONE - x);
  endfunction

  // Input fields
  logic [VAL_W-1:0] hue, saturation, brightness;
  assign hue        = s_axis_tdata[VAL_W-1:0];
  assign saturation = s_axis_tdata[2*VAL_W-1:VAL_W];
  assign brightness = s_axis_tdata[3*VAL_W-1:2*VAL_W];

  // Stage valid bits and ready chain
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  assign rdy5 = !v5 || m_axis_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Stage 1: hue*6 split into sector and fraction, p factor
  logic [H6_W-1:0]      h6;
  logic [SECT_W-1:0]    s1_sect;
  logic [FRAC_BITS-1:0] s1_f;
  logic [VAL_W-1:0]     s1_sat, s1_val, s1_pf;
  logic                 s1_zero;
  assign h6 = (H6_W'(hue) << 2) + (H6_W'(hue) << 1);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sect <= h6[H6_W-1:FRAC_BITS];
      s1_f    <= h6[FRAC_BITS-1:0];
      s1_sat  <= saturation;
      s1_val  <= brightness;
      s1_pf   <= sub_one(saturation);
      s1_zero <= (saturation == '0);
    end
  end

  // Stage 2: s*f and s*(1-f)
  logic [2*VAL_W-1:0] prod_sf, prod_sfc;
  logic [VAL_W-1:0]   s2_sf, s2_sfc, s2_val, s2_pf;
  logic [SECT_W-1:0]  s2_sect;
  logic               s2_zero;
  assign prod_sf  = (2*VAL_W)'(s1_sat) * (2*VAL_W)'(s1_f);
  assign prod_sfc = (2*VAL_W)'(s1_sat) * (2*VAL_W)'(ONE - VAL_W'(s1_f));

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_sf   <= prod_sf[FRAC_BITS+VAL_W-1:FRAC_BITS];
      s2_sfc  <= prod_sfc[FRAC_BITS+VAL_W-1:FRAC_BITS];
      s2_val  <= s1_val;
      s2_pf   <= s1_pf;
      s2_sect <= s1_sect;
      s2_zero <= s1_zero;
    end
  end

  // Stage 3: q and t factors
  logic [VAL_W-1:0]  s3_qf, s3_tf, s3_pf, s3_val;
  logic [SECT_W-1:0] s3_sect;
  logic              s3_zero;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_qf   <= sub_one(s2_sf);
      s3_tf   <= sub_one(s2_sfc);
      s3_pf   <= s2_pf;
      s3_val  <= s2_val;
      s3_sect <= s2_sect;
      s3_zero <= s2_zero;
    end
  end

  // Stage 4: brightness times each factor, truncated
  logic [2*VAL_W-1:0] prod_p, prod_q, prod_t;
  logic [VAL_W-1:0]   s4_p, s4_q, s4_t, s4_val;
  logic [SECT_W-1:0]  s4_sect;
  logic               s4_zero;
  assign prod_p = (2*VAL_W)'(s3_val) * (2*VAL_W)'(s3_pf);
  assign prod_q = (2*VAL_W)'(s3_val) * (2*VAL_W)'(s3_qf);
  assign prod_t = (2*VAL_W)'(s3_val) * (2*VAL_W)'(s3_tf);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_p    <= prod_p[FRAC_BITS+VAL_W-1:FRAC_BITS];
      s4_q    <= prod_q[FRAC_BITS+VAL_W-1:FRAC_BITS];
      s4_t    <= prod_t[FRAC_BITS+VAL_W-1:FRAC_BITS];
      s4_val  <= s3_val;
      s4_sect <= s3_sect;
      s4_zero <= s3_zero;
    end
  end

  // Stage 5: sector select into the output register
  logic [VAL_W-1:0] red_next, green_next, blue_next;
  logic [VAL_W-1:0] red, green, blue;

  always_comb begin
    red_next   = s4_val;
    green_next = s4_val;
    blue_next  = s4_val;
    if (!s4_zero) begin
      case (s4_sect)
        SECT_YELLOW: begin
          red_next  = s4_q;
          blue_next = s4_p;
        end
        SECT_GREEN: begin
          red_next  = s4_p;
          blue_next = s4_t;
        end
        SECT_CYAN: begin
          red_next   = s4_p;
          green_next = s4_q;
        end
        SECT_BLUE: begin
          red_next   = s4_t;
          green_next = s4_p;
        end
        SECT_MAGENTA: begin
          green_next = s4_p;
          blue_next  = s4_q;
        end
        default: begin
          // red sector, hue of one and above
          green_next = s4_t;
          blue_next  = s4_p;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = DATA_W'({blue, green, red});

  // Pad bits come from the zero extension above
  if (PAD_W < 0) begin : g_bad_width
    $error("DATA_W too narrow for three channels");
  end

endmodule

>>> hdl/hsv2rgb_check.sv
// Port-level checker for hsv_to_rgb_converter, with its bind statement.
// Depends on hsv2rgb_pkg and the converter's port list.
module hsv2rgb_check #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF,
  parameter int DATA_W    = ((3 * (FRAC_BITS + 1) + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [DATA_W-1:0] s_axis_tdata,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata
);
  import hsv2rgb_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

  // Words taken but not yet delivered
  logic [CNT_W-1:0] inflight;
  logic             s_take, m_take;
  assign s_take = s_axis_tvalid && s_axis_tready;
  assign m_take = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(s_take) - CNT_W'(m_take);
    end
  end

  // Stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // Pipeline never holds more than its stages
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(PIPE_DEPTH))
    else $error("more words in flight than stages");

  // No output word without a word taken before it
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> inflight != '0)
    else $error("output word with nothing in flight");

  // A free output side leaves the input side open
  a_open: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // An offered input word is fully known
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid |-> !$isunknown(s_axis_tdata))
    else $error("input word has unknown bits");

endmodule

bind hsv_to_rgb_converter hsv2rgb_check #(
  .FRAC_BITS(FRAC_BITS),
  .DATA_W   (DATA_W)
) u_hsv2rgb_check (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> verif/hsv_to_rgb_converter_test.sv
// Self-checking testbench for hsv_to_rgb_converter: a table of corner pixels,
// then random pixels under random idles on both stream sides.
// Depends on hsv2rgb_pkg and the converter RTL.
module hsv_to_rgb_converter_test;
  import hsv2rgb_pkg::*;

  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int DATA_W    = ((3 * VAL_W + 7) / 8) * 8;
  localparam int PAD_W     = DATA_W - 3 * VAL_W;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
  localparam int HUE_SECTORS = 6;
  localparam int N_PROBES    = 24;
  localparam int N_RANDOM    = 1100;
  localparam int IDLE_PCT    = 38;
  localparam int STALL_LIMIT = 1000;

  typedef logic [VAL_W-1:0] val_t;
  // packed so that the last field lands in the low bits of tdata
  typedef struct packed {val_t bright; val_t sat; val_t hue;} hsv_t;
  typedef struct packed {val_t blue; val_t green; val_t red;} rgb_t;

  // corner pixels; known=1 rows carry a hand-written color
  typedef struct {
    int hue, sat, bright;
    bit known;
    int red, green, blue;
  } probe_t;

  probe_t probe_tab [N_PROBES] = '{
    '{0,      0,      0,      1, 0,      0,      0},       // all zero
    '{0,      0,      65536,  1, 65536,  65536,  65536},   // gray, full brightness
    '{43690,  0,      30000,  1, 30000,  30000,  30000},   // gray ignores hue
    '{131071, 0,      131071, 1, 131071, 131071, 131071},  // gray, over-range passes
    '{0,      65536,  65536,  1, 65536,  0,      0},       // pure red
    '{65536,  65536,  65536,  1, 65536,  0,      0},       // hue one wraps to red
    '{65536,  65536,  40000,  1, 40000,  0,      0},       // wrapped red, dimmed
    '{0,      65536,  0,      1, 0,      0,      0},       // black
    '{5461,   65536,  65536,  0, 0, 0, 0},                 // one pixel per sector
    '{16384,  65536,  65536,  0, 0, 0, 0},
    '{27307,  65536,  65536,  0, 0, 0, 0},
    '{38229,  65536,  65536,  0, 0, 0, 0},
    '{49152,  65536,  65536,  0, 0, 0, 0},
    '{60075,  65536,  65536,  0, 0, 0, 0},
    '{65535,  65536,  65536,  0, 0, 0, 0},                 // end of last sector
    '{32768,  65536,  65536,  0, 0, 0, 0},                 // sector edge, f = 0
    '{10923,  32768,  50000,  0, 0, 0, 0},                 // half saturation
    '{100000, 40000,  60000,  0, 0, 0, 0},                 // hue above one
    '{131071, 65536,  65536,  0, 0, 0, 0},                 // largest hue
    '{20000,  131071, 65536,  0, 0, 0, 0},                 // saturation above one
    '{30000,  50000,  131071, 0, 0, 0, 0},                 // brightness above one
    '{131071, 131071, 131071, 0, 0, 0, 0},                 // every field at max
    '{33000,  1,      65536,  0, 0, 0, 0},                 // smallest saturation
    '{21845,  65536,  1,      0, 0, 0, 0}                  // smallest brightness
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;

  rgb_t rgb_owed_q[$];   // colors due from the converter, oldest first
  rgb_t next_rgb;        // color for the word now on s_axis
  bit   steady = 1'b0;   // no idling on either side while set
  int   fail_count = 0;
  int   colors_seen = 0;
  int   stall_cycles = 0;

  hsv_to_rgb_converter i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // brightness times (1 - x), factor clamped at zero, floor
  function automatic val_t scaled(longint unsigned v, longint unsigned x);
    longint unsigned factor;
    factor = (x >= ONE) ? 64'd0 : ONE - x;
    return val_t'((v * factor) >> FRAC_BITS);
  endfunction

  function automatic rgb_t convert_pixel(hsv_t px);
    longint unsigned s, v, h6, f;
    logic [SECT_W-1:0] sect;
    val_t p, q, t;
    rgb_t c;
    s = px.sat;
    v = px.bright;
    c = '{blue: px.bright, green: px.bright, red: px.bright};
    if (s != 0) begin
      h6   = 64'(px.hue) * HUE_SECTORS;
      sect = SECT_W'(h6 >> FRAC_BITS);
      f    = h6 & (ONE - 1);
      p    = scaled(v, s);
      q    = scaled(v, (s * f) >> FRAC_BITS);
      t    = scaled(v, (s * (ONE - f)) >> FRAC_BITS);
      case (sect)
        SECT_YELLOW: begin
          c.red = q; c.blue = p;
        end
        SECT_GREEN: begin
          c.red = p; c.blue = t;
        end
        SECT_CYAN: begin
          c.red = p; c.green = q;
        end
        SECT_BLUE: begin
          c.red = t; c.green = p;
        end
        SECT_MAGENTA: begin
          c.green = p; c.blue = q;
        end
        // sector 0, hue of one and beyond
        default: begin
          c.green = t; c.blue = p;
        end
      endcase
    end
    return c;
  endfunction

  // mostly legal pixels, some gray, some over-range, some corner values
  function automatic val_t pick_field(int kind, int legal_max);
    int corner;
    if (kind < 78) return val_t'($urandom_range(0, legal_max));
    if (kind < 88) return val_t'($urandom);
    corner = $urandom_range(0, 5);
    case (corner)
      0: return '0;
      1: return val_t'(1);
      2: return val_t'(ONE - 1);
      3: return val_t'(ONE);
      4: return '1;
      default: return val_t'($urandom);
    endcase
  endfunction

  function automatic hsv_t random_pixel();
    int kind;
    hsv_t px;
    kind       = $urandom_range(0, 99);
    px.hue     = pick_field(kind, int'(ONE));
    px.sat     = (kind >= 70 && kind < 78) ? '0 : pick_field(kind, int'(ONE));
    px.bright  = pick_field(kind, int'(ONE));
    return px;
  endfunction

  // drive one word from a falling edge, return at the falling edge after it is taken
  task automatic send_pixel(input hsv_t px, input rgb_t rgb);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < IDLE_PCT) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, px};
    next_rgb = rgb;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (rgb_owed_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input val_t want, input val_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // record taken words, check colors, watch for a hang
  always @(posedge clk) begin
    rgb_t got, want;
    bit   moved;
    if (!rst) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        rgb_owed_q = {rgb_owed_q, next_rgb};
        moved = 1'b1;
      end
      if ($isunknown(m_axis_tvalid)) begin
        $error("m_axis_tvalid unknown after reset");
        fail_count++;
      end else if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        colors_seen++;
        got = m_axis_tdata[3*VAL_W-1:0];
        if (rgb_owed_q.size() == 0) begin
          $error("color %h with no pixel pending", got);
          fail_count++;
        end else begin
          want = rgb_owed_q.pop_front();
          check_field("red",   want.red,   got.red);
          check_field("green", want.green, got.green);
          check_field("blue",  want.blue,  got.blue);
          if (m_axis_tdata[DATA_W-1:3*VAL_W] !== '0) begin
            $error("pad: expected 0, got %h", m_axis_tdata[DATA_W-1:3*VAL_W]);
            fail_count++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    hsv_t px;
    rgb_t rgb;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // corner table
    foreach (probe_tab[i]) begin
      px = '{bright: val_t'(probe_tab[i].bright), sat: val_t'(probe_tab[i].sat),
             hue: val_t'(probe_tab[i].hue)};
      if (probe_tab[i].known)
        rgb = '{blue: val_t'(probe_tab[i].blue), green: val_t'(probe_tab[i].green),
                red: val_t'(probe_tab[i].red)};
      else
        rgb = convert_pixel(px);
      send_pixel(px, rgb);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // random pixels; one full drain midway, one stretch with no idles
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 550) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      steady = (n >= 700 && n < 900);
      px = random_pixel();
      send_pixel(px, convert_pixel(px));
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (4 * PIPE_DEPTH) @(negedge clk);
    $display("Checked %0d colors from %0d table pixels and %0d random pixels,",
             colors_seen, N_PROBES, N_RANDOM);
    $display("covering every sector, gray, wrapped hue and over-range fields under backpressure.");
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> hsv_to_rgb_converter.f
hdl/hsv2rgb_pkg.sv
hdl/hsv_to_rgb_converter.sv
hdl/hsv2rgb_check.sv
verif/hsv_to_rgb_converter_test.sv
